/* hdl/rtc_snapshot_normalizer_macros.svh */
// ----------------------------------------------------------------------------
// rtc snapshot normaliser assertion macros
// concurrent checks on posedge clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef RTC_SNAPSHOT_NORMALIZER_MACROS_SVH
`define RTC_SNAPSHOT_NORMALIZER_MACROS_SVH
`ifndef ASSERT_OFF
`define RSN_ASSERT(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("rsn: assertion failed");
`define RSN_ASSERT_NEXT(label, ck, rn, cond, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (cons)) \
        else $error("rsn: assertion failed");
`else
`define RSN_ASSERT(label, ck, rn, prop)
`define RSN_ASSERT_NEXT(label, ck, rn, cond, cons)
`endif
`endif

/* hdl/rsn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsn_pkg
// shared types and constants of the rtc snapshot normaliser
// ----------------------------------------------------------------------------
package rsn_pkg;

    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned YEAR_W        = 16;
    localparam int unsigned CUR_YEAR_W    = 14;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 14;

    localparam logic [CUR_YEAR_W-1:0] DEFAULT_PIVOT_YEAR = 14'd2000;

    // status register b bits
    localparam int unsigned STATUS_BINARY_BIT = 2;
    localparam int unsigned STATUS_H24_BIT    = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_USE_CENTURY = 1'b0,
        CFG_PIVOT_YEAR  = 1'b1
    } cfg_index_t;

    // one matched snapshot, raw bytes plus the mode bits of status b
    typedef struct packed {
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] minute;
        logic [BYTE_W-1:0] hour;
        logic [BYTE_W-1:0] day;
        logic [BYTE_W-1:0] month;
        logic [BYTE_W-1:0] year;
        logic [BYTE_W-1:0] century;
        logic              binary_mode;
        logic              hour_24;
    } snap_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* hdl/rsn_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsn_front
// drops busy snapshots, compares with the kept copy, queues matches
// ----------------------------------------------------------------------------
`include "rtc_snapshot_normalizer_macros.svh"
module rsn_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             update_busy,
    input  logic [rsn_pkg::BYTE_W-1:0]       second_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       minute_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       hour_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       day_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       month_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       year_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       century_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]       status_b,
    input  logic                             use_century,
    output logic                             push,
    output rsn_pkg::snap_entry_t             push_entry
);

    localparam int unsigned SNAP_W = 7 * rsn_pkg::BYTE_W;

    logic [SNAP_W-1:0] last_reg;
    logic [SNAP_W-1:0] last_next;
    logic              valid_reg;
    logic              valid_next;
    logic [SNAP_W-1:0] snap;
    logic              match;
    logic              taken;

    // century byte counts as zero when no century register is present
    assign snap  = {second_raw, minute_raw, hour_raw, day_raw, month_raw, year_raw,
                    (use_century ? century_raw : {rsn_pkg::BYTE_W{1'b0}})};
    assign match = valid_reg && (snap == last_reg);
    assign taken = accept && !update_busy;
    assign push  = taken && match;

    always_comb
    begin
        push_entry             = '0;
        push_entry.second      = snap[6*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.minute      = snap[5*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.hour        = snap[4*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.day         = snap[3*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.month       = snap[2*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.year        = snap[1*rsn_pkg::BYTE_W +: rsn_pkg::BYTE_W];
        push_entry.century     = snap[0 +: rsn_pkg::BYTE_W];
        push_entry.binary_mode = status_b[rsn_pkg::STATUS_BINARY_BIT];
        push_entry.hour_24     = status_b[rsn_pkg::STATUS_H24_BIT];
    end

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        if (taken)
        begin
            valid_next = !match;
            if (!match)
            begin
                last_next = snap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // kept bytes only matter while valid
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    `RSN_ASSERT_NEXT(a_match_drops_copy, clk, rst_n, push, !valid_reg)
    `RSN_ASSERT_NEXT(a_mismatch_keeps, clk, rst_n, taken && !match, valid_reg && (last_reg == $past(snap)))

endmodule

/* hdl/rsn_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsn_fifo
// short queue of matched snapshots between front and back
// ----------------------------------------------------------------------------
`include "rtc_snapshot_normalizer_macros.svh"
module rsn_fifo #(
    parameter int unsigned DEPTH = rsn_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rsn_pkg::snap_entry_t  push_entry,
    input  logic                  pop,
    output rsn_pkg::snap_entry_t  head,
    output rsn_pkg::fifo_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rsn_pkg::snap_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RSN_ASSERT(a_no_overflow, clk, rst_n, !(push && status.full))
    `RSN_ASSERT(a_no_underflow, clk, rst_n, !(pop && status.empty))

endmodule

/* hdl/rsn_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsn_back
// decodes queued snapshots into binary time and full year, output register
// ----------------------------------------------------------------------------
`include "rtc_snapshot_normalizer_macros.svh"
module rsn_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rsn_pkg::fifo_status_t                q_status,
    input  rsn_pkg::snap_entry_t                 head,
    input  logic                                 use_century,
    input  logic [rsn_pkg::CUR_YEAR_W-1:0]       pivot_year,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rsn_pkg::BYTE_W-1:0]           seconds,
    output logic [rsn_pkg::BYTE_W-1:0]           minutes,
    output logic [rsn_pkg::BYTE_W-1:0]           hours,
    output logic [rsn_pkg::BYTE_W-1:0]           day_of_month,
    output logic [rsn_pkg::BYTE_W-1:0]           month_number,
    output logic [rsn_pkg::YEAR_W-1:0]           full_year
);

    localparam int unsigned CY_W    = rsn_pkg::CUR_YEAR_W;
    localparam int unsigned RECIP   = 5243;   // ceil(2^19 / 100)
    localparam int unsigned SHIFT   = 19;
    localparam int unsigned Q_W     = 8;
    localparam int unsigned PROD_W  = SHIFT + Q_W;
    localparam logic [Q_W-1:0]  Q_RESET    = Q_W'(rsn_pkg::DEFAULT_PIVOT_YEAR / 100);
    localparam logic [CY_W-1:0] BASE_RESET = CY_W'((rsn_pkg::DEFAULT_PIVOT_YEAR / 100) * 100);

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return 8'(v[3:0]) + 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0});
    endfunction

    // value is at most 139 here
    function automatic logic [7:0] mod_24(input logic [7:0] v);
        logic [7:0] r;
        if (v >= 8'd120)
            r = v - 8'd120;
        else if (v >= 8'd96)
            r = v - 8'd96;
        else if (v >= 8'd72)
            r = v - 8'd72;
        else if (v >= 8'd48)
            r = v - 8'd48;
        else if (v >= 8'd24)
            r = v - 8'd24;
        else
            r = v;
        return r;
    endfunction

    logic [PROD_W-1:0]     prod;
    logic [Q_W-1:0]        q_reg;
    logic [CY_W-1:0]       base_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            sec_d;
    logic [7:0]            min_d;
    logic [7:0]            hour_d;
    logic [7:0]            day_d;
    logic [7:0]            mon_d;
    logic [7:0]            yr_d;
    logic [7:0]            cen_d;
    logic [7:0]            hour_sum;
    logic [15:0]           year_d;
    logic [15:0]           year_win;
    logic [7:0]            seconds_reg;
    logic [7:0]            minutes_reg;
    logic [7:0]            hours_reg;
    logic [7:0]            day_reg;
    logic [7:0]            month_reg;
    logic [15:0]           year_reg;

    // century base of the window: (pivot year / 100) * 100, two stages
    assign prod = PROD_W'(pivot_year) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= Q_RESET;
            base_reg <= BASE_RESET;
        end
        else
        begin
            q_reg    <= prod[SHIFT +: Q_W];
            base_reg <= CY_W'(CY_W'(q_reg) * CY_W'(100));
        end
    end

    assign pop        = !q_status.empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_comb
    begin
        if (head.binary_mode)
        begin
            sec_d  = head.second;
            min_d  = head.minute;
            hour_d = head.hour;
            day_d  = head.day;
            mon_d  = head.month;
            yr_d   = head.year;
            cen_d  = head.century;
        end
        else
        begin
            sec_d  = bcd_to_bin(head.second);
            min_d  = bcd_to_bin(head.minute);
            hour_d = {head.hour[7], 7'(head.hour[3:0]) + 7'({head.hour[6:4], 3'b000})
                                  + 7'({head.hour[6:4], 1'b0})};
            day_d  = bcd_to_bin(head.day);
            mon_d  = bcd_to_bin(head.month);
            yr_d   = bcd_to_bin(head.year);
            cen_d  = bcd_to_bin(head.century);
        end

        // pm hour in 12-hour mode
        hour_sum = {1'b0, hour_d[6:0]} + 8'd12;
        if (!head.hour_24 && hour_d[7])
        begin
            hour_d = mod_24(hour_sum);
        end

        year_win = 16'(yr_d) + 16'(base_reg);
        if (year_win < 16'(pivot_year))
        begin
            year_win = year_win + 16'd100;
        end
        if (use_century)
        begin
            year_d = 16'(yr_d) + 16'(16'(cen_d) * 16'd100);
        end
        else
        begin
            year_d = year_win;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seconds_reg <= sec_d;
            minutes_reg <= min_d;
            hours_reg   <= hour_d;
            day_reg     <= day_d;
            month_reg   <= mon_d;
            year_reg    <= year_d;
        end
    end

    assign out_valid    = valid_reg;
    assign seconds      = seconds_reg;
    assign minutes      = minutes_reg;
    assign hours        = hours_reg;
    assign day_of_month = day_reg;
    assign month_number = month_reg;
    assign full_year    = year_reg;

    `RSN_ASSERT_NEXT(a_pop_loads_output, clk, rst_n, pop, valid_reg)

endmodule

/* hdl/rtc_snapshot_normalizer.sv */
`timescale 1ns / 1ps
// path: a matching snapshot is written into the queue, then popped into the output register
// throughput: one snapshot per cycle while in_stall is low, held by the two-entry queue and the output register
// busy and first-of-pair snapshots give no result
// input stalls in the cycle of a register write and the one after, while the window settles
// reset: kept snapshot invalid, queue and output empty, use_century 0, pivot year 2000
// ----------------------------------------------------------------------------
// rtc_snapshot_normalizer
// double-read rtc snapshot check with bcd, 12-hour and year normalisation
// ----------------------------------------------------------------------------
module rtc_snapshot_normalizer #(
    parameter int unsigned QUEUE_DEPTH = rsn_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_write,
    input  logic [rsn_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rsn_pkg::CFG_DATA_W-1:0]       cfg_data,
    // snapshot input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 update_busy,
    input  logic [rsn_pkg::BYTE_W-1:0]           second_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           minute_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           hour_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           day_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           month_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           year_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           century_raw,
    input  logic [rsn_pkg::BYTE_W-1:0]           status_b,
    // decoded time output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rsn_pkg::BYTE_W-1:0]           seconds,
    output logic [rsn_pkg::BYTE_W-1:0]           minutes,
    output logic [rsn_pkg::BYTE_W-1:0]           hours,
    output logic [rsn_pkg::BYTE_W-1:0]           day_of_month,
    output logic [rsn_pkg::BYTE_W-1:0]           month_number,
    output logic [rsn_pkg::YEAR_W-1:0]           full_year
);

    // configuration registers
    logic                               use_century_reg;
    logic                               use_century_next;
    logic [rsn_pkg::CUR_YEAR_W-1:0]     pivot_year_reg;
    logic [rsn_pkg::CUR_YEAR_W-1:0]     pivot_year_next;
    // set for the cycle after a write, while the window base catches up
    logic                               cfg_settle_reg;

    // front to queue to back
    logic                               accept;
    logic                               push;
    logic                               pop;
    rsn_pkg::snap_entry_t               push_entry;
    rsn_pkg::snap_entry_t               head;
    rsn_pkg::fifo_status_t              q_status;

    always_comb
    begin
        use_century_next = use_century_reg;
        pivot_year_next  = pivot_year_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                rsn_pkg::CFG_USE_CENTURY: use_century_next = cfg_data[0];
                rsn_pkg::CFG_PIVOT_YEAR:  pivot_year_next  = cfg_data;
                default:                  use_century_next = use_century_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_century_reg <= 1'b0;
            pivot_year_reg  <= rsn_pkg::DEFAULT_PIVOT_YEAR;
            cfg_settle_reg  <= 1'b0;
        end
        else
        begin
            use_century_reg <= use_century_next;
            pivot_year_reg  <= pivot_year_next;
            cfg_settle_reg  <= cfg_write;
        end
    end

    // a transfer is taken whenever the queue has room, even with a result waiting;
    // held off while the two-stage century base follows a register write
    assign in_stall = q_status.full || cfg_write || cfg_settle_reg;
    assign accept   = in_valid && !in_stall;

    // front: busy filter, compare against kept snapshot, queue on a match
    rsn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .update_busy (update_busy),
        .second_raw  (second_raw),
        .minute_raw  (minute_raw),
        .hour_raw    (hour_raw),
        .day_raw     (day_raw),
        .month_raw   (month_raw),
        .year_raw    (year_raw),
        .century_raw (century_raw),
        .status_b    (status_b),
        .use_century (use_century_reg),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decoupling queue
    rsn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: decode and present the result
    rsn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .use_century  (use_century_reg),
        .pivot_year   (pivot_year_reg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .seconds      (seconds),
        .minutes      (minutes),
        .hours        (hours),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .full_year    (full_year)
    );

endmodule
